// File: rtl/heading_lowpass_with_wrap_defines.svh
// ----------------------------------------------------------------------------
// heading_lowpass_with_wrap_defines.svh
// Assertion macros shared by the heading smoother RTL.
// ----------------------------------------------------------------------------
`ifndef HEADING_LOWPASS_WITH_WRAP_DEFINES_SVH
`define HEADING_LOWPASS_WITH_WRAP_DEFINES_SVH

// same-cycle implication, checked on the rising clock outside reset
`define HLW_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on the rising clock outside reset
`define HLW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/hlw_pkg.sv
// ----------------------------------------------------------------------------
// hlw_pkg
// Types and constants of the heading smoother.
// ----------------------------------------------------------------------------
package hlw_pkg;

   // width of the filter history words
   localparam int HIST_BITS = 32;
   // width of the filter sum before saturation
   localparam int SUM_BITS  = 36;

   typedef logic signed [HIST_BITS-1:0] hist_type;
   typedef logic signed [SUM_BITS-1:0]  sum_type;

   localparam hist_type HIST_MAX = 32'sh7fff_ffff;
   localparam hist_type HIST_MIN = 32'sh8000_0000;

   // item kinds
   typedef enum logic {
      KIND_SAMPLE = 1'b0,
      KIND_LOAD   = 1'b1
   } kind_type;

   // clamp the filter sum to the history range
   function automatic hist_type sat_sum(input sum_type value);
      sum_type hi;
      sum_type lo;
      hi = SUM_BITS'(HIST_MAX);
      lo = SUM_BITS'(HIST_MIN);
      if (value > hi) begin
         sat_sum = HIST_MAX;
      end else if (value < lo) begin
         sat_sum = HIST_MIN;
      end else begin
         sat_sum = value[HIST_BITS-1:0];
      end
   endfunction

endpackage

// File: rtl/hlw_div3.sv
// ----------------------------------------------------------------------------
// hlw_div3
// Signed floor division by three through a reciprocal multiply.
// ----------------------------------------------------------------------------
module hlw_div3 #(
   parameter int WIDTH = 33
) (
   input  logic signed [WIDTH-1:0] num,
   output logic signed [WIDTH-1:0] quo
);

   // magnitude width; a negative value is folded with a one's complement
   localparam int MAG_BITS = WIDTH - 1;
   localparam int PROD_BITS = 2 * MAG_BITS;
   // ceil(2^WIDTH / 3): exact floor(u/3) for every u below 2^MAG_BITS
   localparam longint unsigned RECIP = ((64'd1 << WIDTH) + 64'd2) / 64'd3;
   localparam logic [MAG_BITS-1:0] RECIP_K = MAG_BITS'(RECIP);

   logic                   neg;
   logic [MAG_BITS-1:0]    mag;
   logic [PROD_BITS-1:0]   prod;
   logic [WIDTH-3:0]       mag_quo;

   // floor(n/3) = -1 - floor(~n/3) for negative n
   assign neg     = num[WIDTH-1];
   assign mag     = neg ? ~num[MAG_BITS-1:0] : num[MAG_BITS-1:0];
   assign prod    = PROD_BITS'(mag) * PROD_BITS'(RECIP_K);
   assign mag_quo = prod[PROD_BITS-1:WIDTH];
   assign quo     = {{2{neg}}, (neg ? ~mag_quo : mag_quo)};

endmodule

// File: rtl/heading_lowpass_with_wrap.sv
// ----------------------------------------------------------------------------
// heading_lowpass_with_wrap
// Heading smoother: third-order low-pass on wrapped heading increments.
// ----------------------------------------------------------------------------
// Takes one beat per clock while req_stall is low and returns one result
// beat per input beat, in order. An accepted beat is held in the first stage
// registers and moves into the result register when that register is free
// or being drained. The first stage forms the wrapped angle difference and
// its scaled divide by six (one reciprocal multiply); the second runs the
// filter sum, saturates it and updates the heading accumulator. The y2/3
// term is divided ahead of time when y1 is replaced, so back-to-back samples
// see no extra latency. A load beat (kind 1) sets the heading to the given
// angle with a zero fraction and leaves the filter history and the last raw
// angle untouched. Angles are binary angles, 2^ANGLE_BITS per turn; the
// accumulator carries FRAC_BITS fraction bits and wraps.
// ----------------------------------------------------------------------------
`include "heading_lowpass_with_wrap_defines.svh"

module heading_lowpass_with_wrap
   import hlw_pkg::*;
#(
   parameter int ANGLE_BITS = 16,
   parameter int FRAC_BITS  = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_kind,
   input  logic signed [ANGLE_BITS-1:0] req_angle,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [ANGLE_BITS-1:0] rsp_heading
);

   localparam int ACC_BITS = ANGLE_BITS + FRAC_BITS;
   // scaled difference d*2^(F-1)+1 before the divide by three
   localparam int NUM_BITS = ANGLE_BITS + FRAC_BITS - 1;
   localparam int EXT_BITS = (NUM_BITS > HIST_BITS) ? NUM_BITS : HIST_BITS;
   localparam logic signed [EXT_BITS-1:0] EXT_MAX = EXT_BITS'(HIST_MAX);
   localparam logic signed [EXT_BITS-1:0] EXT_MIN = EXT_BITS'(HIST_MIN);

   // handshake
   logic adv;
   logic req_accept;
   logic s2_fire;

   // first stage
   logic                         s1_valid_ff, s1_valid_in;
   kind_type                     s1_kind_ff;
   hist_type                     s1_x0_ff;
   logic signed [ANGLE_BITS-1:0] s1_angle_ff;
   logic signed [ANGLE_BITS-1:0] last_raw_ff, last_raw_in;
   logic signed [ANGLE_BITS-1:0] diff;
   logic signed [NUM_BITS-1:0]   x_num;
   logic signed [NUM_BITS-1:0]   x_quo;
   logic signed [EXT_BITS-1:0]   x_ext;
   hist_type                     x0_in;

   // filter state
   hist_type                     x1_ff, x2_ff, x3_ff;
   hist_type                     y1_ff;
   hist_type                     y2q_ff, y2q_in;
   logic signed [HIST_BITS:0]    y1_inc;
   logic signed [HIST_BITS:0]    y1_quo;
   sum_type                      x_pair;
   sum_type                      y_sum;
   hist_type                     y0;
   logic [ACC_BITS-1:0]          acc_ff, acc_in;

   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [ANGLE_BITS-1:0] rsp_heading_ff;

   // pipeline moves when the result register is free or being drained
   assign adv        = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = s1_valid_ff && !adv;
   assign req_accept = req_valid && !req_stall;
   assign s2_fire    = s1_valid_ff && adv;

   // wrapped difference, scaled by 2^(F-1) with the rounding one added
   assign diff  = req_angle - last_raw_ff;
   assign x_num = {diff, {(FRAC_BITS-2){1'b0}}, 1'b1};

   hlw_div3 #(.WIDTH(NUM_BITS)) u_div_x (
      .num (x_num),
      .quo (x_quo)
   );

   // clamp x0 to the history range
   always_comb begin
      x_ext = EXT_BITS'(x_quo);
      if (x_ext > EXT_MAX) begin
         x0_in = HIST_MAX;
      end else if (x_ext < EXT_MIN) begin
         x0_in = HIST_MIN;
      end else begin
         x0_in = x_ext[HIST_BITS-1:0];
      end
   end

   always_comb begin
      last_raw_in = last_raw_ff;
      if (req_accept && (kind_type'(req_kind) == KIND_SAMPLE)) begin
         last_raw_in = req_angle;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s2_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         last_raw_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         last_raw_ff <= last_raw_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_kind_ff  <= kind_type'(req_kind);
         s1_x0_ff    <= x0_in;
         s1_angle_ff <= req_angle;
      end
   end

   // round(y1/3) prepared for the next sample, where y1 becomes y2
   assign y1_inc = (HIST_BITS+1)'(y1_ff) + (HIST_BITS+1)'(1);

   hlw_div3 #(.WIDTH(HIST_BITS+1)) u_div_y (
      .num (y1_inc),
      .quo (y1_quo)
   );

   assign y2q_in = y1_quo[HIST_BITS-1:0];

   // filter sum: x0 + x3 + 3(x1 + x2) - round(y2/3)
   assign x_pair = SUM_BITS'(x1_ff) + SUM_BITS'(x2_ff);
   assign y_sum  = SUM_BITS'(s1_x0_ff) + SUM_BITS'(x3_ff) + (x_pair <<< 1) + x_pair
                 - SUM_BITS'(y2q_ff);
   assign y0     = sat_sum(y_sum);

   // heading accumulator, wraps modulo a turn
   always_comb begin
      if (s1_kind_ff == KIND_LOAD) begin
         acc_in = {s1_angle_ff, {FRAC_BITS{1'b0}}};
      end else begin
         acc_in = acc_ff + ACC_BITS'(y0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x1_ff  <= '0;
         x2_ff  <= '0;
         x3_ff  <= '0;
         y1_ff  <= '0;
         y2q_ff <= '0;
         acc_ff <= '0;
      end else if (s2_fire) begin
         acc_ff <= acc_in;
         if (s1_kind_ff == KIND_SAMPLE) begin
            x3_ff  <= x2_ff;
            x2_ff  <= x1_ff;
            x1_ff  <= s1_x0_ff;
            y1_ff  <= y0;
            y2q_ff <= y2q_in;
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s2_fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_fire) begin
         rsp_heading_ff <= acc_in[ACC_BITS-1:FRAC_BITS];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_heading = rsp_heading_ff;

   // checks
   `HLW_ASSERT_NEXT(a_fire_gives_result, s2_fire, rsp_valid_ff, "stage two beat lost")
   `HLW_ASSERT_NEXT(a_load_heading, s2_fire && (s1_kind_ff == KIND_LOAD),
      rsp_heading_ff == $past(s1_angle_ff), "load beat heading mismatch")
   `HLW_ASSERT_NEXT(a_load_keeps_filter, s2_fire && (s1_kind_ff == KIND_LOAD),
      $stable(x1_ff) && $stable(y1_ff) && $stable(y2q_ff), "load beat disturbed filter state")
   `HLW_ASSERT_NEXT(a_raw_only_on_sample, !(req_accept && (req_kind == KIND_SAMPLE)),
      $stable(last_raw_ff), "last raw angle changed without a sample")
   `HLW_ASSERT_NOW(a_no_overrun, s1_valid_ff && rsp_valid_ff && rsp_stall, req_stall,
      "input accepted into a blocked stage")

endmodule
